/* hdl/lik_pkg.sv */
// shared constants, types and tables for the leg inverse kinematics pipeline
`timescale 1ns / 1ps
`default_nettype none
package lik_pkg;

  // angles are Q24 radians
  localparam int ANG_W = 28;
  // cordic datapath width
  localparam int CW = 36;
  // count result width before it is cut to each field
  localparam int CNT_W = 12;
  localparam int SCALE_W = 32;
  localparam int COUNT_SHIFT = 48;
  localparam logic [SCALE_W-1:0] COUNT_SCALE = 32'd3281113323;

  localparam logic signed [ANG_W-1:0] ANG_PI = 28'sd52707179;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353589;
  localparam logic signed [ANG_W-1:0] ANG_157 = 28'sd26340229;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [24] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
    28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
    28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
    28'sd256, 28'sd128, 28'sd64, 28'sd32,
    28'sd16, 28'sd8, 28'sd4, 28'sd2
  };

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_COXA = 2'd0;
  localparam cfg_idx_t REG_FEMUR = 2'd1;
  localparam cfg_idx_t REG_TIBIA = 2'd2;

  // outcome of the law-of-cosines range check
  typedef enum logic [1:0] {
    LC_NORM = 2'd0,
    LC_ZERO = 2'd1,
    LC_PI   = 2'd2
  } lc_kind_t;

endpackage
`default_nettype wire

/* hdl/lik_isqrt.sv */
// pipelined integer square root, one root bit per stage, with sideband
`timescale 1ns / 1ps
`default_nettype none
module lik_isqrt #(
  parameter int IW = 24,
  parameter int SW = 8
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [IW-1:0]         val,
  input  wire logic [SW-1:0]         side_in,
  output logic      [(IW+1)/2-1:0]   root,
  output logic                       rem_nz,
  output logic      [SW-1:0]         side_out
);
  localparam int RW = (IW + 1) / 2;
  localparam int VW = 2 * RW;

  logic [RW:0]   rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [VW-1:0] val_q  [RW];
  logic [SW-1:0] side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [RW:0]   rem_i;
    logic [RW-1:0] root_i;
    logic [VW-1:0] val_i;
    logic [SW-1:0] side_i;
    logic [RW+2:0] cand;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign val_i  = VW'(val);
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign val_i  = val_q[k-1];
      assign side_i = side_q[k-1];
    end

    always_comb begin
      cand  = {rem_i, val_i[VW-1 -: 2]};
      trial = {1'b0, root_i, 2'b01};
      ge    = (cand >= trial);
      diff  = cand - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[RW:0] : cand[RW:0];
        root_q[k] <= {root_i[RW-2:0], ge};
        val_q[k]  <= {val_i[VW-3:0], 2'b00};
        side_q[k] <= side_i;
      end
    end
  end

  assign root     = root_q[RW-1];
  assign rem_nz   = |rem_q[RW-1];
  assign side_out = side_q[RW-1];
endmodule
`default_nettype wire

/* hdl/lik_cordic.sv */
// pipelined vectoring cordic giving atan2(y, x) in Q24 radians
`timescale 1ns / 1ps
`default_nettype none
module lik_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [lik_pkg::CW-1:0]   y_in,
  input  wire logic signed [lik_pkg::CW-1:0]   x_in,
  output logic      signed [lik_pkg::ANG_W-1:0] ang
);
  import lik_pkg::*;

  logic signed [CW-1:0]    x_q    [STAGES+1];
  logic signed [CW-1:0]    y_q    [STAGES+1];
  logic signed [ANG_W-1:0] z_q    [STAGES+1];
  logic                    zero_q [STAGES+1];

  logic signed [CW-1:0]    x0;
  logic signed [CW-1:0]    y0;
  logic signed [ANG_W-1:0] z0;

  // fold the left half plane into the right one
  always_comb begin
    x0 = x_in;
    y0 = y_in;
    z0 = '0;
    if (x_in[CW-1]) begin
      if (!y_in[CW-1]) begin
        x0 = y_in;
        y0 = -x_in;
        z0 = ANG_HALF_PI;
      end else begin
        x0 = -y_in;
        y0 = x_in;
        z0 = -ANG_HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      zero_q[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_it
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 pos;

    always_comb begin
      dx  = y_q[i] >>> i;
      dy  = x_q[i] >>> i;
      pos = !y_q[i][CW-1] && (y_q[i] != '0);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN_TAB[i];
        end
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  assign ang = zero_q[STAGES] ? '0 : z_q[STAGES];
endmodule
`default_nettype wire

/* hdl/lik_counts.sv */
// angle to servo count conversion, scale multiply then truncate toward zero
`timescale 1ns / 1ps
`default_nettype none
module lik_counts (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [2:0][lik_pkg::ANG_W-1:0]    ang,
  input  wire logic                              flag_in,
  output logic      [2:0][lik_pkg::CNT_W-1:0]    cnt,
  output logic                                   flag_out
);
  import lik_pkg::*;

  localparam int PW = ANG_W + SCALE_W;

  logic [PW-1:0] prod [3];
  logic          neg  [3];
  logic          flag_q;

  for (genvar i = 0; i < 3; i++) begin : g_ch
    logic [ANG_W-1:0] mag;
    logic [CNT_W-1:0] c;

    assign mag = ang[i][ANG_W-1] ? (~ang[i] + 1'b1) : ang[i];
    assign c   = prod[i][COUNT_SHIFT +: CNT_W];

    always_ff @(posedge clk) begin
      if (en) begin
        neg[i]  <= ang[i][ANG_W-1];
        prod[i] <= PW'(mag) * PW'(COUNT_SCALE);
        cnt[i]  <= neg[i] ? (~c + 1'b1) : c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag_q   <= flag_in;
      flag_out <= flag_q;
    end
  end
endmodule
`default_nettype wire

/* hdl/leg_ik_three_joint.sv */
// throughput: one word per cycle; the whole pipeline advances together and holds on stall
// stage count is set by four root extractors (12, 12 and two 32 in parallel) and the cordics
// reset: rst clears the valid bits and sets the lengths to 50, 80 and 120 mm
// no clearing pass; input is accepted in the first cycle after reset
`timescale 1ns / 1ps
`default_nettype none
module leg_ik_three_joint #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [39:0]       s_tdata,   // foot_x, foot_y, foot_z, zero fill
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [39:0]       m_tdata,   // coxa_offset, femur_offset, tibia_offset, zero fill
  output logic      [0:0]        m_tuser,   // unreachable
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire lik_pkg::cfg_idx_t cfg_index,
  input  wire logic [9:0]        cfg_data
);
  import lik_pkg::*;

  localparam int SQ1_IW = 24;
  localparam int SQ1_RW = (SQ1_IW + 1) / 2;
  localparam int SQ2_IW = 24;
  localparam int SQ2_RW = (SQ2_IW + 1) / 2;
  localparam int SQ3_IW = 64;
  localparam int SQ3_RW = (SQ3_IW + 1) / 2;
  localparam int LAT = 3 + SQ1_RW + 3 + SQ2_RW + 4 + SQ3_RW + (CORDIC_STAGES + 1) + 1 + 2;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] z;
    logic [22:0]        zz;
  } sq1_side_t;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] z;
    logic signed [12:0] reach;
  } sq2_side_t;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] z;
    logic signed [12:0] reach;
    logic signed [25:0] n2;
    lc_kind_t           kind2;
    logic               flag;
  } sq3_side_t;

  typedef struct packed {
    logic signed [25:0] n3;
    lc_kind_t           kind3;
  } sq3b_side_t;

  typedef struct packed {
    lc_kind_t kind2;
    lc_kind_t kind3;
    logic     flag;
  } tail_t;

  typedef struct packed {
    lc_kind_t    kind;
    logic        flag;
    logic [24:0] dm;
    logic [24:0] dp;
  } lc_class_t;

  function automatic lc_class_t lc_classify(logic signed [25:0] n, logic [23:0] d);
    lc_class_t          r;
    logic signed [25:0] ds;
    logic signed [25:0] sm;
    logic signed [25:0] sp;
    ds     = signed'({2'b00, d});
    sm     = ds - n;
    sp     = ds + n;
    r.dm   = sm[24:0];
    r.dp   = sp[24:0];
    r.kind = LC_NORM;
    r.flag = 1'b0;
    if (d == '0) begin
      r.flag = 1'b1;
      r.kind = n[25] ? LC_PI : LC_ZERO;
    end else if (n >= ds) begin
      r.kind = LC_ZERO;
      r.flag = (n != ds);
    end else if (n <= -ds) begin
      r.kind = LC_PI;
      r.flag = (n != -ds);
    end
    return r;
  endfunction

  // configuration
  logic [9:0] coxa_len;
  logic [9:0] femur_len;
  logic [9:0] tibia_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coxa_len  <= 10'd50;
      femur_len <= 10'd80;
      tibia_len <= 10'd120;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COXA:  coxa_len  <= cfg_data;
        REG_FEMUR: femur_len <= cfg_data;
        REG_TIBIA: tibia_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic vld [LAT];

  assign adv      = !vld[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  // input word, squares, horizontal radius squared
  logic signed [11:0] ax, ay, az;
  logic signed [11:0] bx, by, bz;
  logic [22:0]        bxx, byy, bzz;
  sq1_side_t          c_side;
  logic [SQ1_IW-1:0]  r2;
  logic signed [23:0] px, py, pz;

  assign px = ax * ax;
  assign py = ay * ay;
  assign pz = az * az;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= s_tdata[11:0];
      ay <= s_tdata[23:12];
      az <= s_tdata[35:24];
      bx <= ax;
      by <= ay;
      bz <= az;
      bxx <= px[22:0];
      byy <= py[22:0];
      bzz <= pz[22:0];
      r2 <= SQ1_IW'(bxx) + SQ1_IW'(byy);
      c_side <= '{x: bx, y: by, z: bz, zz: bzz};
    end
  end

  logic [SQ1_RW-1:0] s_root;
  logic              s_rem_nz;
  sq1_side_t         s_side;

  lik_isqrt #(.IW(SQ1_IW), .SW($bits(sq1_side_t))) u_sq1 (
    .clk(clk), .en(adv), .val(r2), .side_in(c_side),
    .root(s_root), .rem_nz(s_rem_nz), .side_out(s_side)
  );

  // reach, then leg length squared
  logic signed [12:0] reach_b;
  sq1_side_t          side_b;
  logic signed [12:0] reach_c;
  sq1_side_t          side_c;
  logic [23:0]        rr_c;
  logic [SQ2_IW-1:0]  im2;
  sq2_side_t          side_d;
  logic signed [12:0] reach_raw;
  logic signed [25:0] rr_full;

  // truncation toward zero nudges a short inexact reach up by one
  assign reach_raw = signed'({1'b0, s_root}) - signed'({3'b000, coxa_len})
                   + {12'd0, (s_rem_nz && ({1'b0, s_root} < {3'b000, coxa_len}))};
  assign rr_full   = reach_b * reach_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      reach_b <= reach_raw;
      side_b  <= s_side;
      reach_c <= reach_b;
      side_c  <= side_b;
      rr_c    <= rr_full[23:0];
      im2     <= rr_c + SQ2_IW'(side_c.zz);
      side_d  <= '{x: side_c.x, y: side_c.y, z: side_c.z, reach: reach_c};
    end
  end

  logic [SQ2_RW-1:0] im;
  logic              im_rem_nz;
  sq2_side_t         side_e;

  lik_isqrt #(.IW(SQ2_IW), .SW($bits(sq2_side_t))) u_sq2 (
    .clk(clk), .en(adv), .val(im2), .side_in(side_d),
    .root(im), .rem_nz(im_rem_nz), .side_out(side_e)
  );

  // law of cosines terms
  logic [19:0]        ff, tt, tf;
  logic [23:0]        ii;
  logic [21:0]        fi;
  sq2_side_t          side_f;
  logic signed [25:0] n2_g, n3_g;
  logic [23:0]        d2_g, d3_g;
  sq2_side_t          side_g;
  lc_class_t          cl2, cl3;
  sq3_side_t          side_h;
  sq3b_side_t         side_hb;
  logic [24:0]        dm2, dp2, dm3, dp3;
  logic [47:0]        p2, p3;
  sq3_side_t          side_i;
  sq3b_side_t         side_ib;
  logic [49:0]        p2_full, p3_full;

  assign cl2     = lc_classify(n2_g, d2_g);
  assign cl3     = lc_classify(n3_g, d3_g);
  assign p2_full = dm2 * dp2;
  assign p3_full = dm3 * dp3;

  always_ff @(posedge clk) begin
    if (adv) begin
      ff     <= femur_len * femur_len;
      tt     <= tibia_len * tibia_len;
      tf     <= tibia_len * femur_len;
      ii     <= im * im;
      fi     <= femur_len * im;
      side_f <= side_e;

      n2_g   <= signed'(26'(ff)) - signed'(26'(tt)) + signed'(26'(ii));
      n3_g   <= signed'(26'(ff)) + signed'(26'(tt)) - signed'(26'(ii));
      d2_g   <= {1'b0, fi, 1'b0};
      d3_g   <= {3'b000, tf, 1'b0};
      side_g <= side_f;

      dm2     <= cl2.dm;
      dp2     <= cl2.dp;
      dm3     <= cl3.dm;
      dp3     <= cl3.dp;
      side_h  <= '{x: side_g.x, y: side_g.y, z: side_g.z, reach: side_g.reach,
                   n2: n2_g, kind2: cl2.kind, flag: cl2.flag | cl3.flag};
      side_hb <= '{n3: n3_g, kind3: cl3.kind};

      p2      <= p2_full[47:0];
      p3      <= p3_full[47:0];
      side_i  <= side_h;
      side_ib <= side_hb;
    end
  end

  // opposite side lengths, scaled by 2^8
  logic [SQ3_RW-1:0] root2, root3;
  logic              r2_nz, r3_nz;
  sq3_side_t         side_j;
  sq3b_side_t        side_jb;

  lik_isqrt #(.IW(SQ3_IW), .SW($bits(sq3_side_t))) u_sq3a (
    .clk(clk), .en(adv), .val({p2, 16'h0000}), .side_in(side_i),
    .root(root2), .rem_nz(r2_nz), .side_out(side_j)
  );

  lik_isqrt #(.IW(SQ3_IW), .SW($bits(sq3b_side_t))) u_sq3b (
    .clk(clk), .en(adv), .val({p3, 16'h0000}), .side_in(side_ib),
    .root(root3), .rem_nz(r3_nz), .side_out(side_jb)
  );

  // four angle units in parallel
  logic signed [ANG_W-1:0] zc, zq1, zq2, zq3;
  tail_t                   dly [CORDIC_STAGES+1];

  lik_cordic #(.STAGES(CORDIC_STAGES)) u_cor_coxa (
    .clk(clk), .en(adv),
    .y_in(CW'(signed'({side_j.x, 16'h0000}))),
    .x_in(CW'(signed'({side_j.y, 16'h0000}))),
    .ang(zc)
  );

  lik_cordic #(.STAGES(CORDIC_STAGES)) u_cor_tilt (
    .clk(clk), .en(adv),
    .y_in(CW'(signed'({side_j.z, 16'h0000}))),
    .x_in(CW'(signed'({side_j.reach, 16'h0000}))),
    .ang(zq1)
  );

  lik_cordic #(.STAGES(CORDIC_STAGES)) u_cor_femur (
    .clk(clk), .en(adv),
    .y_in(signed'(CW'(root2))),
    .x_in(CW'(signed'({side_j.n2, 8'h00}))),
    .ang(zq2)
  );

  lik_cordic #(.STAGES(CORDIC_STAGES)) u_cor_tibia (
    .clk(clk), .en(adv),
    .y_in(signed'(CW'(root3))),
    .x_in(CW'(signed'({side_jb.n3, 8'h00}))),
    .ang(zq3)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dly[0] <= '{kind2: side_j.kind2, kind3: side_jb.kind3,
                  flag: side_j.flag | (r2_nz & r3_nz & 1'b0)};
      for (int k = 1; k <= CORDIC_STAGES; k++) dly[k] <= dly[k-1];
    end
  end

  // joint angles
  logic signed [ANG_W-1:0] q2, q3;
  logic [2:0][ANG_W-1:0]   ang;
  logic                    flag_k;

  always_comb begin
    case (dly[CORDIC_STAGES].kind2)
      LC_NORM: q2 = zq2;
      LC_PI:   q2 = ANG_PI;
      default: q2 = '0;
    endcase
    case (dly[CORDIC_STAGES].kind3)
      LC_NORM: q3 = zq3;
      LC_PI:   q3 = ANG_PI;
      default: q3 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang[0] <= zc;
      ang[1] <= q2 - zq1;
      ang[2] <= q3 - ANG_157;
      flag_k <= dly[CORDIC_STAGES].flag;
    end
  end

  logic [2:0][CNT_W-1:0] cnt;
  logic                  flag_o;

  lik_counts u_counts (
    .clk(clk), .en(adv), .ang(ang), .flag_in(flag_k),
    .cnt(cnt), .flag_out(flag_o)
  );

  assign m_tdata = {7'd0, cnt[2][9:0], cnt[1][11:0], cnt[0][10:0]};
  assign m_tuser = flag_o;

  // checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("pipeline stalled with empty output");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0]) else $error("accepted word not in first stage");

  a_femur_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_FEMUR |=> femur_len == $past(cfg_data))
    else $error("femur length write lost");
endmodule
`default_nettype wire
